// ----- hdl/rbgd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbgd_pkg
// Types and codes shared by the rotary/button gesture decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rbgd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned LimitW = 16;
  localparam int unsigned PosW   = 16;
  localparam int unsigned EvW    = 4;
  localparam int unsigned CfgIdxW = 8;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  // config register indexes
  localparam logic [CfgIdxW-1:0] REG_CLICK_LIMIT = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_DCLICK_GAP  = 8'd1;

  localparam logic [LimitW-1:0] CLICK_LIMIT_RST = 16'd300;
  localparam logic [LimitW-1:0] DCLICK_GAP_RST  = 16'd150;

  // event codes
  localparam logic [EvW-1:0] EV_NONE       = 4'd0;
  localparam logic [EvW-1:0] EV_SCROLL_UP  = 4'd1;
  localparam logic [EvW-1:0] EV_SCROLL_DN  = 4'd2;
  localparam logic [EvW-1:0] EV_HSCROLL_UP = 4'd3;
  localparam logic [EvW-1:0] EV_HSCROLL_DN = 4'd4;
  localparam logic [EvW-1:0] EV_DSCROLL_UP = 4'd5;
  localparam logic [EvW-1:0] EV_DSCROLL_DN = 4'd6;
  localparam logic [EvW-1:0] EV_HOLD       = 4'd7;
  localparam logic [EvW-1:0] EV_RELEASE    = 4'd8;
  localparam logic [EvW-1:0] EV_CLICK      = 4'd9;
  localparam logic [EvW-1:0] EV_DCLICK     = 4'd10;

  typedef struct packed {
    logic [LimitW-1:0] click_limit_ms;
    logic [LimitW-1:0] double_click_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             button_level;
    logic             phase_b;
    logic             phase_a;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic [EvW-1:0]         event_code;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/rbgd_step.sv -----
// ----------------------------------------------------------------------------
// rbgd_step
// Detent and button gesture logic with its state; one sample per enable.
// ----------------------------------------------------------------------------
`default_nettype none

module rbgd_step
  import rbgd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output result_t       res_o
);

  localparam logic [2:0] GS_UP      = 3'd0;
  localparam logic [2:0] GS_DOWN    = 3'd1;
  localparam logic [2:0] GS_PRE     = 3'd2;
  localparam logic [2:0] GS_HOLD    = 3'd3;
  localparam logic [2:0] GS_CLICK   = 3'd4;
  localparam logic [2:0] GS_DOUBLE  = 3'd5;
  localparam logic [2:0] GS_SCROLL  = 3'd6;
  localparam logic [2:0] GS_DSCROLL = 3'd7;

  logic             last_a_q, last_a_d;
  logic [2:0]       state_q, state_d;
  logic [TimeW-1:0] stamp_q, stamp_d;
  logic [PosW-1:0]  count_q, count_d;

  logic             detent, pressed, up;
  logic [TimeW-1:0] elapsed;
  logic             over_click, within_gap;
  logic [EvW-1:0]   ev;

  assign pressed    = ~item_i.button_level;
  assign detent     = item_i.phase_a & ~last_a_q;
  assign up         = (item_i.phase_b == item_i.phase_a);
  assign elapsed    = item_i.now_ms - stamp_q;
  assign over_click = elapsed > {{(TimeW-LimitW){1'b0}}, cfg_i.click_limit_ms};
  assign within_gap = elapsed <= {{(TimeW-LimitW){1'b0}}, cfg_i.double_click_gap_ms};

  always_comb begin
    last_a_d = item_i.phase_a;
    state_d  = state_q;
    stamp_d  = stamp_q;
    count_d  = count_q;
    ev       = EV_NONE;
    if (detent) begin
      count_d = up ? count_q + 1'b1 : count_q - 1'b1;
      if (!pressed) begin
        ev = up ? EV_SCROLL_UP : EV_SCROLL_DN;
      end else if (state_q == GS_DOUBLE || state_q == GS_DSCROLL) begin
        state_d = GS_DSCROLL;
        ev      = up ? EV_DSCROLL_UP : EV_DSCROLL_DN;
      end else begin
        state_d = GS_SCROLL;
        ev      = up ? EV_HSCROLL_UP : EV_HSCROLL_DN;
      end
    end else if (pressed) begin
      case (state_q)
        GS_UP: begin
          state_d = GS_PRE;
          stamp_d = item_i.now_ms;
        end
        GS_PRE: begin
          if (over_click) begin
            state_d = GS_HOLD;
            stamp_d = item_i.now_ms;
            ev      = EV_HOLD;
          end
        end
        GS_CLICK: begin
          if (within_gap) begin
            state_d = GS_DOUBLE;
            stamp_d = item_i.now_ms;
          end
        end
        default: ;
      endcase
    end else begin
      case (state_q)
        GS_PRE: begin
          if (!over_click) begin
            state_d = GS_CLICK;
            stamp_d = item_i.now_ms;
          end else begin
            state_d = GS_UP;
            ev      = EV_RELEASE;
          end
        end
        GS_CLICK: begin
          if (!within_gap) begin
            state_d = GS_UP;
            ev      = EV_CLICK;
          end
        end
        GS_HOLD: begin
          state_d = GS_UP;
          ev      = EV_RELEASE;
        end
        GS_DOUBLE: begin
          state_d = GS_UP;
          ev      = EV_DCLICK;
        end
        default: state_d = GS_UP;
      endcase
    end
  end

  assign res_o.event_code = ev;
  assign res_o.position   = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q <= 1'b1;
      state_q  <= GS_UP;
      stamp_q  <= '0;
      count_q  <= '0;
    end else if (en_i) begin
      last_a_q <= last_a_d;
      state_q  <= state_d;
      stamp_q  <= stamp_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(state_q) && $stable(stamp_q) && $stable(count_q))
    else $error("state changed without a sample");

  a_count_on_detent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !detent |=> $stable(count_q))
    else $error("position moved without a detent");

  a_no_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != GS_DOWN)
    else $error("unused down state entered");

  a_pressed_detent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && detent && pressed |=> state_q == GS_SCROLL || state_q == GS_DSCROLL)
    else $error("pressed detent did not enter a scroll state");
`endif

endmodule

`default_nettype wire

// ----- hdl/rotary_button_gesture_decoder_core.sv -----
// ----------------------------------------------------------------------------
// rotary_button_gesture_decoder_core
// Rotary encoder and push-button gesture decoder, one result per sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pin sample per word (phase A/B, active-low button,
//   millisecond timestamp). m_axis returns exactly one word per sample:
//   event code (0 = none) and the running signed detent position.
//   cfg carries register writes: index 0 click limit, 1 double-click gap,
//   other indexes are dropped. cfg_ready_o is always high; write only idle.
// Timing:
//   Input register, then rbgd_step decode logic into the output register.
//   m_axis_tvalid rises once the sample has moved from the input register
//   into the output register. Throughput is one word per cycle while m_axis
//   is not stalled, set by the per-sample state update in rbgd_step.
// Stall:
//   A stalled m_axis holds its word; one more sample waits in the input
//   register, after which s_axis_tready drops until the output is taken.
// Reset:
//   Limits return to 300 / 150 ms, position to zero, button state to up,
//   phase A history to high. Both pipeline stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_button_gesture_decoder_core
  import rbgd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // phase_a[0], phase_b[1], button_level[2], now_ms[34:3], zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // event_code[3:0], position[19:4], zero pad
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [LimitW-1:0]   cfg_data_i
);

  cfg_t     cfg_q;
  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q;
  logic     out_valid_q, out_valid_d;
  result_t  out_res_q;
  result_t  step_res;
  logic     advance, in_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_limit_ms      <= CLICK_LIMIT_RST;
      cfg_q.double_click_gap_ms <= DCLICK_GAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CLICK_LIMIT: cfg_q.click_limit_ms      <= cfg_data_i;
        REG_DCLICK_GAP:  cfg_q.double_click_gap_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.phase_a      <= s_axis_tdata[0];
      in_item_q.phase_b      <= s_axis_tdata[1];
      in_item_q.button_level <= s_axis_tdata[2];
      in_item_q.now_ms       <= s_axis_tdata[TimeW+2:3];
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  rbgd_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-PosW-EvW){1'b0}}, out_res_q.position,
                          out_res_q.event_code};

endmodule

`default_nettype wire

// ----- dv/rotary_button_gesture_decoder_core_test.sv -----
// ----------------------------------------------------------------------------
// rotary_button_gesture_decoder_core_test
// Self-checking bench for the rotary/button gesture decoder. Pin samples are
// streamed in with random source gaps and sink stalls. A behavioral decoder
// in the bench predicts every output word (event code and detent position),
// and each word is compared field by field in arrival order. Directed cases
// cover scroll directions, click, hold, double-click, pressed scrolls and
// timestamp wrap. Randomized gesture sequences then run under several limit
// settings, including zero and full scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rotary_button_gesture_decoder_core_test;
  import rbgd_pkg::*;

  localparam int QuietLimit = 2000;

  typedef enum logic [2:0] {
    GS_UP, GS_DOWN, GS_PRESSED, GS_HOLD, GS_CLICK, GS_SECOND, GS_SCROLL, GS_DSCROLL
  } gesture_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [LimitW-1:0]   cfg_data_i = '0;

  rotary_button_gesture_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // decoder shadow state
  logic [LimitW-1:0]    click_limit_q = CLICK_LIMIT_RST;
  logic [LimitW-1:0]    dclick_gap_q  = DCLICK_GAP_RST;
  logic                 last_a_q      = 1'b1;
  gesture_e             gesture_q     = GS_UP;
  logic [TimeW-1:0]     press_stamp_q = '0;
  logic signed [PosW-1:0] detent_pos_q = '0;

  result_t pending_events[$];
  int      mismatches = 0;
  int      samples_sent = 0;
  int      quiet_cycles = 0;
  bit      src_idle = 1'b1;
  bit      snk_idle = 1'b1;
  bit      calm = 1'b0;

  // stimulus-side pin levels and time
  logic             cur_a = 1'b1;
  logic             cur_btn = 1'b1;
  logic [TimeW-1:0] clock_ms = '0;

  function automatic result_t gesture_decode(input in_item_t smp);
    result_t          res;
    logic [TimeW-1:0] elapsed;
    logic             pressed;
    logic             up;
    elapsed = smp.now_ms - press_stamp_q;
    pressed = !smp.button_level;
    res.event_code = EV_NONE;
    if (smp.phase_a && !last_a_q) begin
      up = (smp.phase_b == smp.phase_a);
      if (!pressed) begin
        res.event_code = up ? EV_SCROLL_UP : EV_SCROLL_DN;
      end else if (gesture_q == GS_SECOND || gesture_q == GS_DSCROLL) begin
        gesture_q = GS_DSCROLL;
        res.event_code = up ? EV_DSCROLL_UP : EV_DSCROLL_DN;
      end else begin
        gesture_q = GS_SCROLL;
        res.event_code = up ? EV_HSCROLL_UP : EV_HSCROLL_DN;
      end
      detent_pos_q = up ? detent_pos_q + 16'sd1 : detent_pos_q - 16'sd1;
    end else if (pressed) begin
      case (gesture_q)
        GS_UP: begin
          gesture_q = GS_PRESSED;
          press_stamp_q = smp.now_ms;
        end
        GS_PRESSED: begin
          if (elapsed > TimeW'(click_limit_q)) begin
            gesture_q = GS_HOLD;
            press_stamp_q = smp.now_ms;
            res.event_code = EV_HOLD;
          end
        end
        GS_CLICK: begin
          if (elapsed <= TimeW'(dclick_gap_q)) begin
            gesture_q = GS_SECOND;
            press_stamp_q = smp.now_ms;
          end
        end
        default: ;
      endcase
    end else begin
      case (gesture_q)
        GS_PRESSED: begin
          if (elapsed <= TimeW'(click_limit_q)) begin
            gesture_q = GS_CLICK;
            press_stamp_q = smp.now_ms;
          end else begin
            gesture_q = GS_UP;
            res.event_code = EV_RELEASE;
          end
        end
        GS_CLICK: begin
          if (elapsed > TimeW'(dclick_gap_q)) begin
            gesture_q = GS_UP;
            res.event_code = EV_CLICK;
          end
        end
        GS_HOLD: begin
          gesture_q = GS_UP;
          res.event_code = EV_RELEASE;
        end
        GS_SECOND: begin
          gesture_q = GS_UP;
          res.event_code = EV_DCLICK;
        end
        default: gesture_q = GS_UP;
      endcase
    end
    last_a_q = smp.phase_a;
    res.position = detent_pos_q;
    return res;
  endfunction

  // send one sample word, advancing the stimulus clock by dt first
  task automatic step(input logic a, input logic b, input logic btn, input logic [TimeW-1:0] dt);
    in_item_t smp;
    clock_ms = clock_ms + dt;
    cur_a = a;
    cur_btn = btn;
    smp.phase_a = a;
    smp.phase_b = b;
    smp.button_level = btn;
    smp.now_ms = clock_ms;
    if (src_idle && !calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tdata <= {{(InDataW - $bits(in_item_t)){1'b0}}, smp};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_events.push_back(gesture_decode(smp));
    samples_sent++;
  endtask

  task automatic push_button(input logic btn, input logic [TimeW-1:0] dt);
    step(cur_a, 1'($urandom_range(0, 1)), btn, dt);
  endtask

  task automatic turn(input logic up);
    step(1'b0, 1'($urandom_range(0, 1)), cur_btn, TimeW'($urandom_range(0, 3)));
    step(1'b1, up, cur_btn, TimeW'($urandom_range(0, 3)));
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LimitW-1:0] val);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_CLICK_LIMIT) click_limit_q = val;
    else if (idx == REG_DCLICK_GAP) dclick_gap_q = val;
  endtask

  // durations clustered around a limit
  function automatic logic [TimeW-1:0] span_near(input logic [LimitW-1:0] lim);
    logic [TimeW-1:0] l;
    l = TimeW'(lim);
    case ($urandom_range(0, 5))
      0: span_near = (l == 0) ? '0 : l - 1;
      1: span_near = l;
      2: span_near = l + 1;
      3: span_near = TimeW'($urandom_range(0, 3));
      default: span_near = TimeW'($urandom_range(0, 2 * l + 2));
    endcase
  endfunction

  task test_scroll();
    step(1'b0, 1'b0, 1'b1, 10);
    step(1'b1, 1'b1, 1'b1, 1);
    step(1'b0, 1'b1, 1'b1, 1);
    step(1'b1, 1'b0, 1'b1, 1);
    step(1'b0, 1'b0, 1'b1, 1);
    step(1'b1, 1'b0, 1'b1, 1);
  endtask

  task test_click_hold();
    step(1'b1, 1'b0, 1'b0, 100);
    step(1'b1, 1'b0, 1'b1, 300);
    step(1'b1, 1'b0, 1'b1, 151);
    step(1'b1, 1'b0, 1'b0, 50);
    step(1'b1, 1'b0, 1'b0, 301);
    step(1'b1, 1'b0, 1'b1, 5);
  endtask

  task test_double_click();
    step(1'b1, 1'b1, 1'b0, 20);
    step(1'b1, 1'b1, 1'b1, 10);
    step(1'b1, 1'b1, 1'b0, 150);
    step(1'b1, 1'b1, 1'b1, 7);
  endtask

  task test_pressed_scroll();
    step(1'b0, 1'b1, 1'b0, 3);
    step(1'b1, 1'b1, 1'b0, 1);
    step(1'b1, 1'b0, 1'b1, 1);
    step(1'b1, 1'b0, 1'b0, 20);
    step(1'b1, 1'b0, 1'b1, 10);
    step(1'b0, 1'b0, 1'b0, 10);
    step(1'b1, 1'b0, 1'b0, 1);
    step(1'b0, 1'b1, 1'b0, 1);
    step(1'b1, 1'b1, 1'b0, 1);
    step(1'b1, 1'b1, 1'b1, 1);
  endtask

  task test_time_wrap();
    clock_ms = 32'hFFFF_FFF0;
    step(1'b1, 1'b0, 1'b0, 0);
    step(1'b1, 1'b0, 1'b1, 32);
    step(1'b1, 1'b0, 1'b1, 200);
  endtask

  task test_ignored_writes();
    write_reg(CfgIdxW'(2), LimitW'($urandom));
    write_reg('1, '0);
  endtask

  task automatic test_gestures(input logic [LimitW-1:0] click_lim,
                               input logic [LimitW-1:0] gap, input int count);
    int target;
    int n;
    write_reg(REG_CLICK_LIMIT, click_lim);
    write_reg(REG_DCLICK_GAP, gap);
    target = samples_sent + count;
    while (samples_sent < target) begin
      src_idle = !calm && ($urandom_range(0, 3) != 0);
      snk_idle = !calm && ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 4);
      case ($urandom_range(0, 11))
        0, 1: begin
          push_button(1'b0, TimeW'($urandom_range(0, 5)));
          push_button(1'b1, span_near(click_limit_q));
          push_button(1'b1, span_near(dclick_gap_q));
          push_button(1'b1, TimeW'(dclick_gap_q) + TimeW'($urandom_range(1, 5)));
        end
        2, 3: begin
          push_button(1'b0, TimeW'($urandom_range(0, 5)));
          push_button(1'b0, span_near(click_limit_q));
          push_button(1'b0, TimeW'($urandom_range(0, 5)));
          push_button(1'b1, TimeW'($urandom_range(0, 5)));
        end
        4, 5: begin
          push_button(1'b0, TimeW'($urandom_range(0, 5)));
          push_button(1'b1, span_near(click_limit_q));
          push_button(1'b0, span_near(dclick_gap_q));
          push_button(1'b0, TimeW'($urandom_range(0, 3)));
          push_button(1'b1, TimeW'($urandom_range(0, 3)));
        end
        6: begin
          push_button(1'b0, TimeW'($urandom_range(0, 5)));
          repeat (n) turn(1'($urandom_range(0, 1)));
          push_button(1'b1, TimeW'($urandom_range(0, 5)));
        end
        7: begin
          push_button(1'b0, TimeW'($urandom_range(0, 5)));
          push_button(1'b1, TimeW'($urandom_range(0, 5)));
          push_button(1'b0, span_near(dclick_gap_q));
          repeat (n) turn(1'($urandom_range(0, 1)));
          push_button(1'b1, TimeW'($urandom_range(0, 5)));
        end
        8: begin
          cur_btn = 1'b1;
          repeat (n) turn(1'($urandom_range(0, 1)));
        end
        9: begin
          repeat (n + 2)
            step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? TimeW'($urandom)
                                            : TimeW'($urandom_range(0, 400)));
        end
        10: begin
          clock_ms = $urandom;
          push_button(1'b0, 0);
          push_button(1'b1, span_near(click_limit_q));
          push_button(1'b1, TimeW'(dclick_gap_q) + 1);
        end
        default: begin
          if (!calm) wait_drain();
        end
      endcase
    end
  endtask

  // sink stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (snk_idle && !calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp %0d got %0d", $realtime, field, want, got);
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (pending_events.size() == 0) begin
        report("unexpected word, event_code", -1, got.event_code);
      end else begin
        want = pending_events.pop_front();
        if (got.event_code !== want.event_code)
          report("event_code", want.event_code, got.event_code);
        if (got.position !== want.position)
          report("position", want.position, got.position);
      end
    end
  end

  // no progress on any channel for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("rotary_button_gesture_decoder_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_scroll();
    test_click_hold();
    test_double_click();
    test_pressed_scroll();
    test_time_wrap();
    test_ignored_writes();
    test_gestures(CLICK_LIMIT_RST, DCLICK_GAP_RST, 250);
    test_gestures('0, '0, 200);
    test_gestures('1, '1, 200);
    test_gestures(LimitW'($urandom_range(1, 40)), LimitW'($urandom_range(1, 40)), 300);
    calm = 1'b1;
    test_gestures(LimitW'($urandom_range(0, 60)), LimitW'($urandom_range(0, 60)), 300);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("rotary_button_gesture_decoder_core: match");
    end else begin
      $display("rotary_button_gesture_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
